@@ rtl/core/pcm_pkg.sv @@
// shared types and constants of the pointwise convolution engine
// no dependencies; every module of the block but the port checker imports this package
`default_nettype none

package pcm_pkg;

  // request kinds carried on in_req_type
  localparam logic [1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [1:0] REQ_BIAS    = 2'd1;
  localparam logic [1:0] REQ_PRELOAD = 2'd2;
  localparam logic [1:0] REQ_SAMPLE  = 2'd3;

  // configuration register indexes and widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FROM_BIAS = 2'd1;
  localparam logic [1:0] GROUP_COUNT_RESET = 2'd2;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 5;
  localparam int VALUE_W  = 32;
  localparam int RESULT_W = 32;

  // fixed-point formats (fraction bits)
  localparam int FEAT_FRAC = 10;
  localparam int WT_FRAC   = 12;
  localparam int ACC_FRAC  = 22;

  // weight columns addressed by in_chan
  localparam int IN_COLUMNS = 32;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // one classified request
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAN_W-1:0]  out_chan;
    logic [CHAN_W-1:0]  in_chan;
    logic [VALUE_W-1:0] value;
    logic               grp_end;    // sample closes a channel group
    logic               pix_end;    // sample closes the pixel
    logic               from_bias;  // group folds onto the bias
  } item_t;

endpackage

`default_nettype wire

@@ rtl/core/pcm_front.sv @@
// front end: configuration registers, sample counting and request tagging
// depends on pcm_pkg
`default_nettype none

module pcm_front #(
  parameter int GROUP_SIZE = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             accept_i,
  input  logic [pcm_pkg::KIND_W-1:0]       req_type_i,
  input  logic [pcm_pkg::CHAN_W-1:0]       out_chan_i,
  input  logic [pcm_pkg::CHAN_W-1:0]       in_chan_i,
  input  logic [pcm_pkg::VALUE_W-1:0]      value_i,
  output pcm_pkg::item_t                   item_o
);
  import pcm_pkg::*;

  localparam int CntW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

  logic [1:0]      group_count_r;
  logic            start_bias_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic            is_sample, grp_end, pix_end;

  assign is_sample = accept_i && (req_type_i == REQ_SAMPLE);
  assign grp_end   = (cnt_r == CntW'(GROUP_SIZE - 1));
  // two groups when the count reads two or three, else one
  assign pix_end   = grp_end && (done_r || !group_count_r[1]);

  always_comb begin
    item_o.kind      = req_type_i;
    item_o.out_chan  = out_chan_i;
    item_o.in_chan   = in_chan_i;
    item_o.value     = value_i;
    item_o.grp_end   = grp_end;
    item_o.pix_end   = pix_end;
    item_o.from_bias = start_bias_r && !done_r;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (is_sample) begin
      if (grp_end) begin
        cnt_nxt  = '0;
        done_nxt = !pix_end;
      end else begin
        cnt_nxt = cnt_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      done_r        <= 1'b0;
      group_count_r <= GROUP_COUNT_RESET;
      start_bias_r  <= 1'b1;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROUP_COUNT:     group_count_r <= cfg_wdata[1:0];
          CFG_START_FROM_BIAS: start_bias_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pcm_queue.sv @@
// short request queue between the front and the back
// depends on pcm_pkg
`default_nettype none

module pcm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  pcm_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output pcm_pkg::item_t data_o,
  output logic           valid_o
);
  import pcm_pkg::*;

  item_t             q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full_o  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_r != '0);
  assign data_o  = q_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= data_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pcm_back.sv @@
// back end: weight columns, one multiply-accumulate lane per output channel,
// group sums and channel accumulators; depends on pcm_pkg
`default_nettype none

module pcm_back #(
  parameter int OUT_CHANNELS  = 32,
  parameter int FEATURE_WIDTH = 16,
  parameter int WEIGHT_WIDTH  = 16,
  parameter int ACC_WIDTH     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcm_pkg::item_t       head_i,
  input  logic                 head_valid_i,
  output logic                 pop_o,
  input  logic                 snap_free_i,
  output logic                 load_o,
  output logic [ACC_WIDTH-1:0] fold_o [OUT_CHANNELS]
);
  import pcm_pkg::*;

  localparam int ProdW    = FEATURE_WIDTH + WEIGHT_WIDTH;
  localparam int ProdExtW = ProdW + ACC_WIDTH;
  localparam int ProdShr  = FEAT_FRAC + WT_FRAC - ACC_FRAC;
  localparam int BiasExtW = WEIGHT_WIDTH + ACC_WIDTH;
  localparam int BiasShl  = ACC_FRAC - WT_FRAC;
  localparam int PreW     = VALUE_W + ACC_WIDTH;

  item_t s1_r, s2_r;
  logic  v1_r, v2_r;
  logic  stall, adv, commit;

  logic signed [FEATURE_WIDTH-1:0] feat;
  logic signed [PreW-1:0]          pre_ext;
  logic [ACC_WIDTH-1:0]            pre_val;

  // a pixel end waits until the result snapshot can take it
  assign stall  = v2_r && (s2_r.kind == REQ_SAMPLE) && s2_r.pix_end && !snap_free_i;
  assign adv    = !stall;
  assign pop_o  = head_valid_i && adv;
  assign commit = v2_r && adv;
  assign load_o = commit && (s2_r.kind == REQ_SAMPLE) && s2_r.pix_end;

  assign feat    = s1_r.value[FEATURE_WIDTH-1:0];
  assign pre_ext = PreW'($signed(s2_r.value));
  assign pre_val = pre_ext[ACC_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pop_o;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= head_i;
      s2_r <= s1_r;
    end
  end

  for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_lane
    logic        [WEIGHT_WIDTH-1:0] wmem [IN_COLUMNS];
    logic signed [WEIGHT_WIDTH-1:0] wrd_r;
    logic signed [ProdW-1:0]        mul;
    logic signed [ProdExtW-1:0]     mul_ext, mul_al;
    logic        [ACC_WIDTH-1:0]    prod_r;
    logic signed [WEIGHT_WIDTH-1:0] bias_r;
    logic signed [BiasExtW-1:0]     bias_ext, bias_al;
    logic        [ACC_WIDTH-1:0]    gs_r, acc_r;
    logic        [ACC_WIDTH-1:0]    gs_add, base, fold;
    logic                           hit_head, hit_s2;

    assign hit_head = (32'(head_i.out_chan) == c);
    assign hit_s2   = (32'(s2_r.out_chan) == c);

    // weight column of this output channel, registered read
    always_ff @(posedge clk) begin
      if (pop_o) begin
        if ((head_i.kind == REQ_WEIGHT) && hit_head)
          wmem[head_i.in_chan] <= head_i.value[WEIGHT_WIDTH-1:0];
        wrd_r <= wmem[head_i.in_chan];
      end
    end

    assign mul     = feat * wrd_r;
    assign mul_ext = ProdExtW'(mul);
    if (ProdShr >= 0) begin : g_prod_shr
      assign mul_al = mul_ext >>> ProdShr;
    end else begin : g_prod_shl
      assign mul_al = mul_ext <<< (-ProdShr);
    end

    always_ff @(posedge clk) begin
      if (adv) prod_r <= mul_al[ACC_WIDTH-1:0];
    end

    assign bias_ext = BiasExtW'(bias_r);
    if (BiasShl >= 0) begin : g_bias_shl
      assign bias_al = bias_ext <<< BiasShl;
    end else begin : g_bias_shr
      assign bias_al = bias_ext >>> (-BiasShl);
    end

    assign gs_add = gs_r + prod_r;
    assign base   = s2_r.from_bias ? bias_al[ACC_WIDTH-1:0] : acc_r;
    assign fold   = base + gs_add;
    assign fold_o[c] = fold;

    always_ff @(posedge clk) begin
      if (commit && (s2_r.kind == REQ_BIAS) && hit_s2)
        bias_r <= s2_r.value[WEIGHT_WIDTH-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        gs_r  <= '0;
        acc_r <= '0;
      end else if (commit) begin
        case (s2_r.kind)
          REQ_PRELOAD: begin
            if (hit_s2) acc_r <= pre_val;
          end
          REQ_SAMPLE: begin
            if (s2_r.grp_end) begin
              acc_r <= fold;
              gs_r  <= '0;
            end else begin
              gs_r <= gs_add;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pcm_drain.sv @@
// result snapshot and drain sequencer, one channel per transaction
// depends on pcm_pkg
`default_nettype none

module pcm_drain #(
  parameter int OUT_CHANNELS = 32,
  parameter int ACC_WIDTH    = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load_i,
  input  logic [ACC_WIDTH-1:0]               acc_i [OUT_CHANNELS],
  output logic                               snap_free_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic [pcm_pkg::CHAN_W-1:0]         chan_o,
  output logic signed [pcm_pkg::RESULT_W-1:0] psum_o,
  output logic                               last_o
);
  import pcm_pkg::*;

  localparam int IdxW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

  logic [RESULT_W-1:0]    snap_r [OUT_CHANNELS];
  logic                   busy_r, busy_nxt;
  logic [IdxW-1:0]        idx_r, idx_nxt;
  logic                   at_last, pop_ok;
  logic [IdxW+CHAN_W-1:0] idx_ext;

  assign at_last     = (idx_r == IdxW'(OUT_CHANNELS - 1));
  assign pop_ok      = pop_i && busy_r;
  assign snap_free_o = !busy_r || (pop_ok && at_last);

  assign empty_o = !busy_r;
  assign psum_o  = snap_r[idx_r];
  assign last_o  = at_last;
  assign idx_ext = {{CHAN_W{1'b0}}, idx_r};
  assign chan_o  = idx_ext[CHAN_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load_i) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (pop_ok) begin
      if (at_last) busy_nxt = 1'b0;
      else idx_nxt = idx_r + IdxW'(1);
    end
  end

  for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_snap
    logic [ACC_WIDTH+RESULT_W-1:0] acc_ext;
    assign acc_ext = {{RESULT_W{1'b0}}, acc_i[c]};
    always_ff @(posedge clk) begin
      if (load_i) snap_r[c] <= acc_ext[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pointwise_conv_mac_engine.sv @@
// top level of the pointwise 1x1 convolution engine
// depends on pcm_pkg, pcm_front, pcm_queue, pcm_back and pcm_drain
//
// usage
//   input channel: a request transaction is taken when in_push is high and
//   in_full is low. weight, bias and preload requests set up the lanes,
//   sample requests bring one feature each, in channel order.
//   result channel: while out_empty is low the oldest result is on the out_
//   ports; it is taken when out_pop is high. a pixel gives OUT_CHANNELS
//   results in channel order, out_last marks the final one.
//   configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 group count, 1 start from bias); only while the block is idle.
// timing
//   one request per cycle is sustained while in_full is low; all lanes
//   multiply-accumulate in parallel, one weight column read per sample from
//   each lane's store. the first result of a pixel shows once the fold of
//   the closing sample is in the snapshot register, then one result per
//   cycle while out_pop is held high. results drain while the next pixel
//   loads; a pixel end arriving before the previous pixel has fully drained
//   holds the back end, and the four-entry queue fills and raises in_full.
// reset
//   rst_n is synchronous, active low. it empties the queue and the result
//   side, zeroes group sums and accumulators and restores the registers.
//   weight and bias stores hold nothing defined until written.
`default_nettype none

module pointwise_conv_mac_engine #(
  parameter int OUT_CHANNELS  = 32,
  parameter int GROUP_SIZE    = 16,
  parameter int FEATURE_WIDTH = 16,
  parameter int WEIGHT_WIDTH  = 16,
  parameter int ACC_WIDTH     = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [pcm_pkg::KIND_W-1:0]          in_req_type,
  input  logic [pcm_pkg::CHAN_W-1:0]          in_out_chan,
  input  logic [pcm_pkg::CHAN_W-1:0]          in_in_chan,
  input  logic signed [pcm_pkg::VALUE_W-1:0]  in_value,
  // result channel
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [pcm_pkg::CHAN_W-1:0]          out_result_chan,
  output logic signed [pcm_pkg::RESULT_W-1:0] out_partial_sum,
  output logic                                out_last,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import pcm_pkg::*;

  logic                 accept;
  item_t                front_item, head_item;
  logic                 head_valid, pop;
  logic                 snap_free, load;
  logic [ACC_WIDTH-1:0] fold [OUT_CHANNELS];

  // a request transaction completes on push with room in the queue
  assign accept = in_push && !in_full;

  // front: registers, sample counting, group and pixel end tagging
  pcm_front #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept_i   (accept),
    .req_type_i (in_req_type),
    .out_chan_i (in_out_chan),
    .in_chan_i  (in_in_chan),
    .value_i    (in_value),
    .item_o     (front_item)
  );

  // queue decouples tagging from the lanes
  pcm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (accept),
    .data_i  (front_item),
    .full_o  (in_full),
    .pop_i   (pop),
    .data_o  (head_item),
    .valid_o (head_valid)
  );

  // back: weight read, multiply, accumulate, fold at group end
  pcm_back #(
    .OUT_CHANNELS  (OUT_CHANNELS),
    .FEATURE_WIDTH (FEATURE_WIDTH),
    .WEIGHT_WIDTH  (WEIGHT_WIDTH),
    .ACC_WIDTH     (ACC_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head_item),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .snap_free_i  (snap_free),
    .load_o       (load),
    .fold_o       (fold)
  );

  // snapshot of the finished pixel, drained one channel at a time
  pcm_drain #(
    .OUT_CHANNELS (OUT_CHANNELS),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .acc_i       (fold),
    .snap_free_o (snap_free),
    .pop_i       (out_pop),
    .empty_o     (out_empty),
    .chan_o      (out_result_chan),
    .psum_o      (out_partial_sum),
    .last_o      (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/core/pcm_port_checker.sv @@
// port-level checks of the pointwise convolution engine and their bind
// depends on pointwise_conv_mac_engine
`default_nettype none

module pcm_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic [4:0]        out_result_chan,
  input logic signed [31:0] out_partial_sum,
  input logic              out_last
);

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results pending after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_result_chan) && $stable(out_partial_sum)
       && $stable(out_last)))
    else $error("result changed while stalled");

  // channels of one pixel follow each other without a gap
  a_next_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=>
      (!out_empty && (out_result_chan == 5'($past(out_result_chan) + 5'd1))))
    else $error("channel sequence broken");

  // a new pixel starts from channel zero
  a_pixel_start: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_last) |=>
      (out_empty || (out_result_chan == 5'd0)))
    else $error("pixel did not start at channel zero");

endmodule

bind pointwise_conv_mac_engine pcm_port_checker u_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_result_chan (out_result_chan),
  .out_partial_sum (out_partial_sum),
  .out_last        (out_last)
);

`default_nettype wire

@@ tb/sv/tb_pointwise_conv_mac_engine.sv @@
`timescale 1ns / 100ps
// self-checking testbench for pointwise_conv_mac_engine: a queued request driver,
// a result monitor and a bit-exact predictor of the 1x1 convolution lanes
// depends on pcm_pkg and the engine rtl only

module tb_pointwise_conv_mac_engine;
  import pcm_pkg::*;

  localparam int NUM_OCH      = 32;
  localparam int GRP_SAMPLES  = 16;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back the queue up
  localparam int IDLE_LIMIT   = 3000;  // quiet cycles before the watchdog gives up
  localparam int DRAIN_CYCLES = 12;    // pipeline depth plus queue, with margin

  // one request transaction as driven on the in_ ports
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [CHAN_W-1:0]  och;
    logic [CHAN_W-1:0]  ich;
    logic [VALUE_W-1:0] value;
  } conv_req_t;

  // one result transaction as seen on the out_ ports
  typedef struct {
    logic [CHAN_W-1:0]   chan;
    logic [RESULT_W-1:0] psum;
    logic                last;
  } chan_result_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [KIND_W-1:0]          in_req_type = '0;
  logic [CHAN_W-1:0]          in_out_chan = '0;
  logic [CHAN_W-1:0]          in_in_chan = '0;
  logic signed [VALUE_W-1:0]  in_value = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic [CHAN_W-1:0]          out_result_chan;
  logic signed [RESULT_W-1:0] out_partial_sum;
  logic                       out_last;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  pointwise_conv_mac_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_out_chan     (in_out_chan),
    .in_in_chan      (in_in_chan),
    .in_value        (in_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result_chan (out_result_chan),
    .out_partial_sum (out_partial_sum),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the lanes and registers
  // ---------------------------------------------------------------------------
  logic [15:0]   wt_mem [NUM_OCH][IN_COLUMNS];
  logic [15:0]   bias_mem [NUM_OCH];
  logic [31:0]   acc_mem [NUM_OCH];
  logic [31:0]   grp_sum [NUM_OCH];
  int            samp_cnt = 0;
  int            grps_done = 0;
  logic [1:0]    pred_groups = GROUP_COUNT_RESET;
  logic          pred_from_bias = 1'b1;
  chan_result_t  expected_sums [$];

  // stimulus side bookkeeping
  conv_req_t     pending_reqs [$];
  conv_req_t     next_req;
  int            ready_cols [$];      // weight columns loaded for every lane
  logic [1:0]    gen_groups = GROUP_COUNT_RESET;
  logic          gen_from_bias = 1'b1;
  int            items_queued = 0;

  // handshake and run control
  int            send_idle_pct = 0;
  int            pop_stall_pct = 0;
  bit            hold_armed = 1'b0;
  int            hold_left = 0;
  bit            req_taken = 1'b0;
  bit            res_taken = 1'b0;
  int            quiet_cycles = 0;
  int            fail_count = 0;
  chan_result_t  exp_res;

  // group count register: zero behaves as one group, three as two
  function automatic int eff_groups(input logic [1:0] g);
    return (g == 2'd0) ? 1 : ((g == 2'd3) ? 2 : int'(g));
  endfunction

  // fold one request transaction into the lane model; a pixel-closing sample
  // queues all 32 channel sums
  task automatic predict_pixel_sums(input conv_req_t r);
    logic signed [15:0] feat;
    logic signed [15:0] wgt;
    logic signed [31:0] prod;
    logic [31:0]        base;
    chan_result_t       res;
    int                 c;
    case (r.kind)
      REQ_WEIGHT:  wt_mem[r.och][r.ich] = r.value[15:0];
      REQ_BIAS:    bias_mem[r.och] = r.value[15:0];
      REQ_PRELOAD: acc_mem[r.och] = r.value;
      default: begin
        feat = r.value[15:0];
        for (c = 0; c < NUM_OCH; c++) begin
          wgt = wt_mem[c][r.ich];
          // q.10 times q.12 lands on q.22 already, no realignment
          prod = feat * wgt;
          grp_sum[c] = grp_sum[c] + prod;
        end
        samp_cnt++;
        if (samp_cnt == GRP_SAMPLES) begin
          samp_cnt = 0;
          for (c = 0; c < NUM_OCH; c++) begin
            base = acc_mem[c];
            // first group of a pixel may start from the bias, shifted q.12 -> q.22
            if (grps_done == 0 && pred_from_bias)
              base = {{16{bias_mem[c][15]}}, bias_mem[c]} << (ACC_FRAC - WT_FRAC);
            acc_mem[c] = base + grp_sum[c];
            grp_sum[c] = '0;
          end
          grps_done++;
          if (grps_done >= eff_groups(pred_groups)) begin
            grps_done = 0;
            for (c = 0; c < NUM_OCH; c++) begin
              res.chan = CHAN_W'(c);
              res.psum = acc_mem[c];
              res.last = (c == NUM_OCH - 1);
              expected_sums.push_back(res);
            end
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // monitor: samples both channels and the config port at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      req_taken = in_push && !in_full;
      res_taken = out_pop && !out_empty;
      if (req_taken) begin
        next_req.kind  = in_req_type;
        next_req.och   = in_out_chan;
        next_req.ich   = in_in_chan;
        next_req.value = in_value;
        predict_pixel_sums(next_req);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROUP_COUNT:     pred_groups = cfg_wdata;
          CFG_START_FROM_BIAS: pred_from_bias = cfg_wdata[0];
          default: ;
        endcase
      end
      if (res_taken) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result transaction, channel %0d sum %0d",
                 out_result_chan, out_partial_sum);
          fail_count++;
        end else begin
          exp_res = expected_sums.pop_front();
          if (out_result_chan !== exp_res.chan) begin
            $error("result_chan: expected %0d, got %0d", exp_res.chan, out_result_chan);
            fail_count++;
          end
          if (out_partial_sum !== exp_res.psum) begin
            $error("partial_sum: expected %0d, got %0d",
                   $signed(exp_res.psum), out_partial_sum);
            fail_count++;
          end
          if (out_last !== exp_res.last) begin
            $error("last: expected %0d, got %0d", exp_res.last, out_last);
            fail_count++;
          end
        end
      end
      // watchdog on cycles with no transaction of any kind
      if (req_taken || res_taken || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: request transactions leave the pending queue at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      // a request on offer stays put until the block takes it
      if (!in_push || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_push     <= 1'b1;
          in_req_type <= next_req.kind;
          in_out_chan <= next_req.och;
          in_in_chan  <= next_req.ich;
          in_value    <= next_req.value;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off once armed
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (hold_armed && !out_empty) begin
        hold_left = HOLD_CYCLES;
        hold_armed = 1'b0;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_req(input logic [1:0] kind, input int och,
                         input int ich, input logic [31:0] value);
    conv_req_t r;
    r.kind  = kind;
    r.och   = CHAN_W'(och);
    r.ich   = CHAN_W'(ich);
    r.value = value;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  // 16-bit quantity in the low half, junk above it; extremes often
  function automatic logic [31:0] pick_q_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v[15:0] = 16'h7FFF;
      1: v[15:0] = 16'h8000;
      2: v[15:0] = 16'h0000;
      3: v[15:0] = 16'hFFFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_acc_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 32'h0000_0000;
      3: v = 32'hFFFF_FFFF;
      default: ;
    endcase
    return v;
  endfunction

  // writes a whole weight column so samples may select it
  task automatic load_column(input int col);
    int c;
    for (c = 0; c < NUM_OCH; c++)
      add_req(REQ_WEIGHT, c, col, pick_q_value());
    ready_cols.push_back(col);
  endtask

  // block idle: nothing left to send, nothing expected, pipeline drained
  task automatic wait_idle();
    do
      @(posedge clk);
    while (pending_reqs.size() != 0 || in_push || expected_sums.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_GROUP_COUNT)
      gen_groups = data;
    else
      gen_from_bias = data[0];
  endtask

  // one whole pixel of samples with random content; noise mixes set-up
  // transactions in between the samples
  task automatic queue_pixel(input bit with_noise);
    int n_samp;
    int k;
    int col_pos;
    n_samp = GRP_SAMPLES * eff_groups(gen_groups);
    if (!gen_from_bias)
      repeat ($urandom_range(6))
        add_req(REQ_PRELOAD, $urandom_range(31), $urandom_range(31), pick_acc_value());
    col_pos = $urandom_range(ready_cols.size() - 1);
    for (k = 0; k < n_samp; k++) begin
      if (with_noise && $urandom_range(99) < 8) begin
        case ($urandom_range(2))
          0: add_req(REQ_PRELOAD, $urandom_range(31), $urandom_range(31),
                     pick_acc_value());
          1: add_req(REQ_BIAS, $urandom_range(31), $urandom_range(31), pick_q_value());
          default: add_req(REQ_WEIGHT, $urandom_range(31),
                           ready_cols[$urandom_range(ready_cols.size() - 1)],
                           pick_q_value());
        endcase
      end
      // mostly walk the loaded columns in order, now and then jump
      if ($urandom_range(3) == 0)
        col_pos = $urandom_range(ready_cols.size() - 1);
      else
        col_pos = (col_pos + 1) % ready_cols.size();
      add_req(REQ_SAMPLE, $urandom_range(31), ready_cols[col_pos], pick_q_value());
    end
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct,
                           input logic [1:0] groups, input logic from_bias,
                           input int n_items);
    int start;
    cfg_write(CFG_GROUP_COUNT, groups);
    cfg_write(CFG_START_FROM_BIAS, {1'b0, from_bias});
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
    start = items_queued;
    while (items_queued - start < n_items)
      queue_pixel(1'b1);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int c;
    int k;
    for (c = 0; c < NUM_OCH; c++) begin
      acc_mem[c] = '0;
      grp_sum[c] = '0;
      bias_mem[c] = '0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // set-up: every bias and a handful of weight columns, edge columns included
    for (c = 0; c < NUM_OCH; c++)
      add_req(REQ_BIAS, c, $urandom_range(31), pick_q_value());
    load_column(0);
    load_column(21);
    load_column(31);
    wait_idle();

    // directed: extreme weights and biases with junk in the unused upper bits
    add_req(REQ_WEIGHT, 0, 0, 32'hA5A5_7FFF);
    add_req(REQ_WEIGHT, 31, 0, 32'h0000_8000);
    add_req(REQ_WEIGHT, 31, 31, 32'hFFFF_8000);
    add_req(REQ_BIAS, 0, 31, 32'h1234_7FFF);
    add_req(REQ_BIAS, 31, 0, 32'hFFFF_8000);
    // preload before a bias-started group is discarded at the group end
    add_req(REQ_PRELOAD, 3, 0, 32'h7FFF_FFFF);
    // first group of a two-group pixel: columns out of order, min feature
    // times min weight summed until the group sum wraps
    for (k = 0; k < GRP_SAMPLES; k++)
      add_req(REQ_SAMPLE, k, (k % 2) ? 5'd0 : 5'd31,
              (k < 12) ? 32'hFFFF_8000 : pick_q_value());
    wait_idle();
    // register change halfway through the pixel: one group now closes it
    cfg_write(CFG_GROUP_COUNT, 2'd1);
    cfg_write(CFG_START_FROM_BIAS, 2'd0);
    // preload halfway through the pixel takes effect at once
    add_req(REQ_PRELOAD, 7, 31, 32'h7FFF_FFFF);
    add_req(REQ_PRELOAD, 8, 0, 32'h8000_0000);
    for (k = 0; k < GRP_SAMPLES; k++)
      add_req(REQ_SAMPLE, 31 - k, (k % 3) ? 5'd0 : 5'd31,
              (k % 2) ? 32'h0000_7FFF : 32'h5A5A_8000);
    wait_idle();

    // random phases, each with its own idling pattern and register setting
    run_phase(0, 0, 2'd2, 1'b1, 32);
    run_phase(82, 0, 2'd1, 1'b0, 32);
    run_phase(0, 82, 2'd3, 1'b1, 32);
    run_phase(24, 24, 2'd0, 1'b0, 32);

    // back-pressure: receiver holds off while the sender keeps offering,
    // so the result side backs up into the input queue
    cfg_write(CFG_GROUP_COUNT, 2'd1);
    cfg_write(CFG_START_FROM_BIAS, 2'd1);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_armed = 1'b1;
    repeat (3)
      queue_pixel(1'b0);
    wait_idle();

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/pcm_pkg.sv
rtl/core/pcm_front.sv
rtl/core/pcm_queue.sv
rtl/core/pcm_back.sv
rtl/core/pcm_drain.sv
rtl/core/pointwise_conv_mac_engine.sv
rtl/core/pcm_port_checker.sv
tb/sv/tb_pointwise_conv_mac_engine.sv
